// ===== rtl/dsdl_pkg.sv =====
// Shared constants, codes and types for the depth-sorted draw list.
`default_nettype none

package dsdl_pkg;

    // Pool size and derived index widths
    localparam int MAX_SLOTS = 64;
    localparam int IDX_W     = $clog2(MAX_SLOTS);
    localparam int CNT_W     = $clog2(MAX_SLOTS + 1);

    // Field widths of the streams and registers
    localparam int CMD_W      = 2;
    localparam int STAT_W     = 2;
    localparam int SLOT_W     = 6;
    localparam int DEPTH_W    = 16;
    localparam int IMAGE_W    = 16;
    localparam int DCNT_W     = 7;
    localparam int VOFS_W     = 25;
    localparam int FV_W       = 24;
    localparam int VC_W       = 8;
    localparam int FI_W       = 24;
    localparam int IC_W       = 8;
    localparam int MM_W       = 7;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_ADDR_W = 3;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 96;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_UNLOAD  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SET_IMG = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ    = 2'd3;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_OK         = 2'd0;
    localparam logic [STAT_W-1:0] STAT_POOL_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NOT_LOADED = 2'd2;
    localparam logic [STAT_W-1:0] STAT_BAD_POS    = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_FIRST_VERTEX = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_VERTEX_COUNT = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_FIRST_INDEX  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_INDEX_COUNT  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_MODELS   = 3'd4;

    // One draw list entry, kept in list order
    typedef struct packed {
        logic signed [DEPTH_W-1:0] depth;
        logic [IMAGE_W-1:0]        image;
        logic [IDX_W-1:0]          slot;
    } entry_t;

    // Port requests from the sequencer to the list store
    typedef struct packed {
        logic             ent_re;
        logic [IDX_W-1:0] ent_raddr;
        logic             ent_we;
        logic [IDX_W-1:0] ent_waddr;
        entry_t           ent_wdata;
        logic             pos_re;
        logic [IDX_W-1:0] pos_raddr;
        logic             pos_we;
        logic [IDX_W-1:0] pos_waddr;
        logic [IDX_W-1:0] pos_wdata;
    } store_req_t;

    // Configuration register file
    typedef struct packed {
        logic [FV_W-1:0] first_vertex;
        logic [VC_W-1:0] vertex_count;
        logic [FI_W-1:0] first_index;
        logic [IC_W-1:0] index_count;
        logic [MM_W-1:0] max_models;
    } cfg_t;

    // Finished command result handed to the output stage
    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [SLOT_W-1:0]  slot;
        logic [SLOT_W-1:0]  position;
        logic [CNT_W-1:0]   count;
        logic [IMAGE_W-1:0] image;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/dsdl_store.sv =====
// List store: entry memory in list order and the slot-to-position map.
`default_nettype none

module dsdl_store (
    input  wire logic                       aclk,
    input  wire dsdl_pkg::store_req_t       req,
    output      dsdl_pkg::entry_t           ent_rdata,
    output      logic [dsdl_pkg::IDX_W-1:0] pos_rdata
);
    import dsdl_pkg::*;

    entry_t           entry_mem_reg [MAX_SLOTS];
    logic [IDX_W-1:0] pos_mem_reg   [MAX_SLOTS];

    // Entry memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (req.ent_we) begin
            entry_mem_reg[req.ent_waddr] <= req.ent_wdata;
        end
        if (req.ent_re) begin
            ent_rdata <= entry_mem_reg[req.ent_raddr];
        end
    end

    // Slot-to-position map
    always_ff @(posedge aclk) begin
        if (req.pos_we) begin
            pos_mem_reg[req.pos_waddr] <= req.pos_wdata;
        end
        if (req.pos_re) begin
            pos_rdata <= pos_mem_reg[req.pos_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/dsdl_ctrl.sv =====
// Command sequencer: slot search, sorted insertion walk, removal shift, image updates, reads.
`default_nettype none

module dsdl_ctrl (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    output      logic                         s_tready,
    input  wire logic [dsdl_pkg::CMD_W-1:0]   cmd_in,
    input  wire logic [dsdl_pkg::SLOT_W-1:0]  handle_in,
    input  wire logic [dsdl_pkg::DEPTH_W-1:0] depth_in,
    input  wire logic [dsdl_pkg::IMAGE_W-1:0] image_in,
    input  wire logic [dsdl_pkg::SLOT_W-1:0]  position_in,
    input  wire logic [dsdl_pkg::MM_W-1:0]    max_models,
    output      dsdl_pkg::store_req_t         store_req,
    input  wire dsdl_pkg::entry_t             ent_rdata,
    input  wire logic [dsdl_pkg::IDX_W-1:0]   pos_rdata,
    output      logic                         res_valid,
    output      dsdl_pkg::result_t            res,
    input  wire logic                         res_free
);
    import dsdl_pkg::*;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_DECODE   = 4'd1;
    localparam logic [3:0] ST_FIND     = 4'd2;
    localparam logic [3:0] ST_WALK     = 4'd3;
    localparam logic [3:0] ST_WALK_CMP = 4'd4;
    localparam logic [3:0] ST_INS      = 4'd5;
    localparam logic [3:0] ST_LOOKUP   = 4'd6;
    localparam logic [3:0] ST_GET      = 4'd7;
    localparam logic [3:0] ST_SHIFT    = 4'd8;
    localparam logic [3:0] ST_SHIFT_WR = 4'd9;
    localparam logic [3:0] ST_RD_GET   = 4'd10;
    localparam logic [3:0] ST_DONE     = 4'd11;

    logic [3:0]                state_reg, state_next;
    logic [CNT_W-1:0]          idx_reg, idx_next;
    logic [IDX_W-1:0]          slot_reg, slot_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [MAX_SLOTS-1:0]      used_reg, used_next;
    logic [CMD_W-1:0]          cmd_reg;
    logic [SLOT_W-1:0]         handle_reg;
    logic signed [DEPTH_W-1:0] depth_reg;
    logic [IMAGE_W-1:0]        image_reg;
    logic [SLOT_W-1:0]         position_reg;
    logic [STAT_W-1:0]         rstat_reg, rstat_next;
    logic [SLOT_W-1:0]         rslot_reg, rslot_next;
    logic [SLOT_W-1:0]         rpos_reg, rpos_next;
    logic [IMAGE_W-1:0]        rimage_reg, rimage_next;

    logic [CNT_W-1:0] limit;
    logic [CNT_W-1:0] idx_inc;
    logic [CNT_W-1:0] idx_dec;
    logic             accept;
    logic             handle_ok;
    logic             pos_ok;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign idx_inc   = idx_reg + 1'b1;
    assign idx_dec   = idx_reg - 1'b1;

    // Active slot limit: min(max_models, pool size)
    assign limit = (int'(max_models) > MAX_SLOTS) ? CNT_W'(MAX_SLOTS) : CNT_W'(max_models);

    assign handle_ok = (int'(handle_reg) < MAX_SLOTS) && used_reg[IDX_W'(handle_reg)];
    assign pos_ok    = (int'(position_reg) < int'(count_reg))
                     && (int'(position_reg) < MAX_SLOTS);

    assign res = '{status: rstat_reg, slot: rslot_reg, position: rpos_reg,
                   count: count_reg, image: rimage_reg};

    // Capture the command on accept
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg      <= cmd_in;
            handle_reg   <= handle_in;
            depth_reg    <= depth_in;
            image_reg    <= image_in;
            position_reg <= position_in;
        end
    end

    // Sequencer state and control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            used_reg  <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            used_reg  <= used_next;
        end
    end

    // Working and result payload registers
    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        slot_reg   <= slot_next;
        rstat_reg  <= rstat_next;
        rslot_reg  <= rslot_next;
        rpos_reg   <= rpos_next;
        rimage_reg <= rimage_next;
    end

    // Next-state and memory request logic
    always_comb begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        slot_next   = slot_reg;
        count_next  = count_reg;
        used_next   = used_reg;
        rstat_next  = rstat_reg;
        rslot_next  = rslot_reg;
        rpos_next   = rpos_reg;
        rimage_next = rimage_reg;
        store_req   = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                rstat_next  = STAT_OK;
                rslot_next  = '0;
                rpos_next   = '0;
                rimage_next = '0;
                unique case (cmd_reg)
                    CMD_LOAD: begin
                        if (int'(count_reg) >= MAX_SLOTS) begin
                            rstat_next = STAT_POOL_FULL;
                            state_next = ST_DONE;
                        end else begin
                            idx_next   = '0;
                            state_next = ST_FIND;
                        end
                    end
                    CMD_UNLOAD, CMD_SET_IMG: begin
                        if (!handle_ok) begin
                            rstat_next = STAT_NOT_LOADED;
                            state_next = ST_DONE;
                        end else begin
                            store_req.pos_re    = 1'b1;
                            store_req.pos_raddr = IDX_W'(handle_reg);
                            state_next          = ST_LOOKUP;
                        end
                    end
                    CMD_READ: begin
                        if (!pos_ok) begin
                            rstat_next = STAT_BAD_POS;
                            state_next = ST_DONE;
                        end else begin
                            store_req.ent_re    = 1'b1;
                            store_req.ent_raddr = IDX_W'(position_reg);
                            state_next          = ST_RD_GET;
                        end
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            // Lowest free slot, one slot per cycle
            ST_FIND: begin
                if (idx_reg >= limit) begin
                    rstat_next = STAT_POOL_FULL;
                    state_next = ST_DONE;
                end else if (!used_reg[idx_reg[IDX_W-1:0]]) begin
                    slot_next  = idx_reg[IDX_W-1:0];
                    idx_next   = count_reg;
                    state_next = ST_WALK;
                end else begin
                    idx_next = idx_inc;
                end
            end
            // Walk down from the tail, moving lower-depth entries up by one
            ST_WALK: begin
                if (idx_reg == '0) begin
                    state_next = ST_INS;
                end else begin
                    store_req.ent_re    = 1'b1;
                    store_req.ent_raddr = idx_dec[IDX_W-1:0];
                    state_next          = ST_WALK_CMP;
                end
            end
            ST_WALK_CMP: begin
                if (depth_reg > ent_rdata.depth) begin
                    store_req.ent_we    = 1'b1;
                    store_req.ent_waddr = idx_reg[IDX_W-1:0];
                    store_req.ent_wdata = ent_rdata;
                    store_req.pos_we    = 1'b1;
                    store_req.pos_waddr = ent_rdata.slot;
                    store_req.pos_wdata = idx_reg[IDX_W-1:0];
                    idx_next            = idx_dec;
                    state_next          = ST_WALK;
                end else begin
                    state_next = ST_INS;
                end
            end
            ST_INS: begin
                store_req.ent_we    = 1'b1;
                store_req.ent_waddr = idx_reg[IDX_W-1:0];
                store_req.ent_wdata = '{depth: depth_reg, image: image_reg, slot: slot_reg};
                store_req.pos_we    = 1'b1;
                store_req.pos_waddr = slot_reg;
                store_req.pos_wdata = idx_reg[IDX_W-1:0];
                used_next[slot_reg] = 1'b1;
                count_next          = count_reg + 1'b1;
                rslot_next          = SLOT_W'(slot_reg);
                rpos_next           = SLOT_W'(idx_reg);
                rimage_next         = image_reg;
                state_next          = ST_DONE;
            end
            // Position of the handle is back; fetch its entry
            ST_LOOKUP: begin
                idx_next            = CNT_W'(pos_rdata);
                rpos_next           = SLOT_W'(pos_rdata);
                rslot_next          = handle_reg;
                store_req.ent_re    = 1'b1;
                store_req.ent_raddr = pos_rdata;
                state_next          = ST_GET;
            end
            ST_GET: begin
                if (cmd_reg == CMD_SET_IMG) begin
                    store_req.ent_we    = 1'b1;
                    store_req.ent_waddr = idx_reg[IDX_W-1:0];
                    store_req.ent_wdata = '{depth: ent_rdata.depth, image: image_reg,
                                            slot: ent_rdata.slot};
                    rimage_next         = image_reg;
                    state_next          = ST_DONE;
                end else begin
                    rimage_next                      = ent_rdata.image;
                    used_next[IDX_W'(handle_reg)]    = 1'b0;
                    count_next                       = count_reg - 1'b1;
                    state_next                       = ST_SHIFT;
                end
            end
            // Close the gap, moving each later entry down by one: read it, then write it back
            ST_SHIFT: begin
                if (idx_reg >= count_reg) begin
                    state_next = ST_DONE;
                end else begin
                    store_req.ent_re    = 1'b1;
                    store_req.ent_raddr = idx_inc[IDX_W-1:0];
                    state_next          = ST_SHIFT_WR;
                end
            end
            ST_SHIFT_WR: begin
                store_req.ent_we    = 1'b1;
                store_req.ent_waddr = idx_reg[IDX_W-1:0];
                store_req.ent_wdata = ent_rdata;
                store_req.pos_we    = 1'b1;
                store_req.pos_waddr = ent_rdata.slot;
                store_req.pos_wdata = idx_reg[IDX_W-1:0];
                idx_next            = idx_inc;
                state_next          = ST_SHIFT;
            end
            ST_RD_GET: begin
                rslot_next  = SLOT_W'(ent_rdata.slot);
                rpos_next   = position_reg;
                rimage_next = ent_rdata.image;
                state_next  = ST_DONE;
            end
            ST_DONE: begin
                if (res_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Draw count always matches the number of loaded slots
    assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(used_reg) == int'(count_reg))
        else $error("draw count out of step with loaded slots");

    // An insertion leaves its slot marked loaded
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_INS) |=> used_reg[$past(slot_reg)])
        else $error("inserted slot not marked loaded");

    // Walks never run past the list
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK || state_reg == ST_SHIFT) |-> (idx_reg <= count_reg))
        else $error("walk index beyond draw count");

    // Count moves by at most one per command step
    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != $past(count_reg)) |->
            (count_reg == $past(count_reg) + 1'b1 || count_reg == $past(count_reg) - 1'b1))
        else $error("draw count jumped");

endmodule

`default_nettype wire

// ===== rtl/dsdl_out.sv =====
// Result stage: vertex offset arithmetic and the output register.
`default_nettype none

module dsdl_out (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            res_valid,
    input  wire dsdl_pkg::result_t               res,
    output      logic                            res_free,
    input  wire dsdl_pkg::cfg_t                  cfg,
    output      logic                            m_tvalid,
    input  wire logic                            m_tready,
    output      logic [dsdl_pkg::OUT_DATA_W-1:0] m_tdata,
    output      logic [dsdl_pkg::STAT_W-1:0]     m_tuser
);
    import dsdl_pkg::*;

    logic                    valid_reg;
    logic [OUT_DATA_W-1:0]   data_reg, data_next;
    logic [STAT_W-1:0]       user_reg;
    logic [VC_W+SLOT_W-1:0]  vc_prod;
    logic [VOFS_W-1:0]       vofs;
    logic                    ok;
    logic                    load;

    assign res_free = !valid_reg || m_tready;
    assign load     = res_valid && res_free;
    assign ok       = (res.status == STAT_OK);

    // first_vertex + vertex_count * slot, modulo 2^25
    assign vc_prod = cfg.vertex_count * res.slot;
    assign vofs    = VOFS_W'(cfg.first_vertex) + VOFS_W'(vc_prod);

    // Error results carry only the status and the count
    always_comb begin
        data_next = '0;
        data_next[18:12] = DCNT_W'(res.count);
        if (ok) begin
            data_next[5:0]   = res.slot;
            data_next[11:6]  = res.position;
            data_next[43:19] = vofs;
            data_next[51:44] = cfg.index_count;
            data_next[75:52] = cfg.first_index;
            data_next[91:76] = res.image;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= data_next;
            user_reg <= res.status;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;

endmodule

`default_nettype wire

// ===== rtl/depth_sorted_draw_list_unit.sv =====
// Depth-sorted draw list: slot pool and descending-depth list, top level.
//
// Usage:
//  s_* carries one command per request (tuser = command, tdata = arguments);
//  m_* returns exactly one result per command (tuser = status).
//  The cfg_we/cfg_addr/cfg_wdata port writes the pool registers; write them
//  only while no command is in flight.
//  One command at a time, run by a sequencer over an entry memory with one
//  write port and one registered read port. A load scans the slots in order
//  for the lowest free one below the active slot limit (up to 64), then
//  walks down from the tail, moving each lower-depth entry up by one before
//  writing the new entry; an unload shifts every later entry down by one.
//  Errors found at decode skip the memory steps.
//  s_tready is high only while the sequencer is idle; a result waiting in the
//  output register does not block the next command, but a finished command
//  holds until the output register is free when the receiver stalls.
//  Reset (aresetn low, synchronous) empties the pool and the list, restores
//  the register defaults and drops m_tvalid; no clearing pass is needed.
`default_nettype none

module depth_sorted_draw_list_unit (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // slave: tuser = command
    input  wire logic                              s_tvalid,
    output      logic                              s_tready,
    // tdata: handle[5:0], depth_key[21:6], image_index[37:22], position[43:38]
    input  wire logic [dsdl_pkg::IN_DATA_W-1:0]    s_tdata,
    input  wire logic [dsdl_pkg::CMD_W-1:0]        s_tuser,
    // master: tuser = status
    output      logic                              m_tvalid,
    input  wire logic                              m_tready,
    // tdata: slot[5:0], draw_position[11:6], draw_count[18:12],
    //        vertex_offset[43:19], entry_index_count[51:44],
    //        entry_first_index[75:52], entry_image[91:76]
    output      logic [dsdl_pkg::OUT_DATA_W-1:0]   m_tdata,
    output      logic [dsdl_pkg::STAT_W-1:0]       m_tuser,
    // configuration write port
    input  wire logic                              cfg_we,
    input  wire logic [dsdl_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [dsdl_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import dsdl_pkg::*;

    cfg_t             cfg_reg;
    store_req_t       store_req;
    entry_t           ent_rdata;
    logic [IDX_W-1:0] pos_rdata;
    logic             res_valid;
    logic             res_free;
    result_t          res;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.first_vertex <= '0;
            cfg_reg.vertex_count <= VC_W'(4);
            cfg_reg.first_index  <= '0;
            cfg_reg.index_count  <= IC_W'(6);
            cfg_reg.max_models   <= MM_W'(64);
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_FIRST_VERTEX: cfg_reg.first_vertex <= cfg_wdata[FV_W-1:0];
                REG_VERTEX_COUNT: cfg_reg.vertex_count <= cfg_wdata[VC_W-1:0];
                REG_FIRST_INDEX:  cfg_reg.first_index  <= cfg_wdata[FI_W-1:0];
                REG_INDEX_COUNT:  cfg_reg.index_count  <= cfg_wdata[IC_W-1:0];
                REG_MAX_MODELS:   cfg_reg.max_models   <= cfg_wdata[MM_W-1:0];
                default: ;
            endcase
        end
    end

    dsdl_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .cmd_in      (s_tuser),
        .handle_in   (s_tdata[5:0]),
        .depth_in    (s_tdata[21:6]),
        .image_in    (s_tdata[37:22]),
        .position_in (s_tdata[43:38]),
        .max_models  (cfg_reg.max_models),
        .store_req   (store_req),
        .ent_rdata   (ent_rdata),
        .pos_rdata   (pos_rdata),
        .res_valid   (res_valid),
        .res         (res),
        .res_free    (res_free)
    );

    dsdl_store u_store (
        .aclk      (aclk),
        .req       (store_req),
        .ent_rdata (ent_rdata),
        .pos_rdata (pos_rdata)
    );

    dsdl_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .res_free  (res_free),
        .cfg       (cfg_reg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire
